/* sv/lrast_pkg.sv */
// Shared types and constants of the line rasterizer.
package lrast_pkg;

  // Input item kinds, carried on in_tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  // Screen size after reset
  localparam int SCREEN_WIDTH_RST  = 320;
  localparam int SCREEN_HEIGHT_RST = 200;

  // Palette index width
  localparam int COLOR_BITS = 8;

  // Per-result status flags
  typedef struct packed {
    logic write_enable;
    logic line_done;
    logic busy_res;
  } lrast_flags_t;

endpackage

/* sv/line_rasterizer_top.sv */
// Top level of the line rasterizer: ports, screen size registers and output skid buffer.
//
// Bresenham line rasterizer with clipping to a configurable screen.
// Input channel (in_*): in_tuser selects the item kind, 0 loads a new line
// (endpoints and color from in_tdata), 1 steps to the next pixel.
// Result channel (out_*): exactly one result item per input item, in order.
// out_tuser is the pixel write enable, out_tlast marks the end point of a line.
// Config channel (cfg_*): index 0 screen width, index 1 screen height; always ready.
// The user must write it only while the block is idle; the block does not enforce this.
// A result is registered into the result register, or into the skid register while a
// result waits, when its input item is accepted. Throughput: one item per clock while
// in_tready is high; each item's step, clip and address work fits between the input
// edge and the result register, with one 10x10 multiply for the address.
// Stall: a two-entry output buffer (result register plus skid register) lets
// one more item in while a result waits; in_tready drops while both are full.
// Reset: the line goes idle, both result entries empty, screen set to 320x200.
module line_rasterizer_top #(
  parameter  int COORD_BITS = 16,
  parameter  int DIM_BITS   = 10,
  localparam int IN_W       = ((4 * COORD_BITS + lrast_pkg::COLOR_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((4 * DIM_BITS + lrast_pkg::COLOR_BITS + 1 + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // input item
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_W-1:0]     in_tdata,   // x_start, y_start, x_end, y_end, line_color, zero pad
  input  logic                in_tuser,   // mode
  // result item
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata,  // pixel_x, pixel_y, pixel_address, pixel_color,
                                          // busy_res, zero pad
  output logic                out_tuser,  // write_enable
  output logic                out_tlast,  // line_done
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_addr,
  input  logic [DIM_BITS-1:0] cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int D     = DIM_BITS;
  localparam int CB    = lrast_pkg::COLOR_BITS;
  localparam int RES_W = OUT_W + 2;

  logic                     in_accept, out_pop;
  logic [D-1:0]             screen_width_r, screen_height_r;
  lrast_pkg::lrast_flags_t  flags;
  logic [D-1:0]             pixel_x, pixel_y;
  logic [2*D-1:0]           pixel_address;
  logic [CB-1:0]            pixel_color;
  logic [RES_W-1:0]         res_new;
  logic [RES_W-1:0]         out_res_r, out_res_nxt, skid_res_r, skid_res_nxt;
  logic                     out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign out_pop   = out_valid_r && out_tready;
  assign cfg_ready = 1'b1;

  // Screen size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= D'(lrast_pkg::SCREEN_WIDTH_RST);
      screen_height_r <= D'(lrast_pkg::SCREEN_HEIGHT_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        lrast_pkg::CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        lrast_pkg::CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lrast_core #(
    .COORD_BITS (COORD_BITS),
    .DIM_BITS   (DIM_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .mode          (in_tuser),
    .x_start       (in_tdata[C-1:0]),
    .y_start       (in_tdata[2*C-1:C]),
    .x_end         (in_tdata[3*C-1:2*C]),
    .y_end         (in_tdata[4*C-1:3*C]),
    .line_color    (in_tdata[4*C+CB-1:4*C]),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .flags         (flags),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color)
  );

  // Pack the result item: tdata fields from bit 0, then tlast, then tuser
  always_comb begin
    res_new                       = '0;
    res_new[D-1:0]                = pixel_x;
    res_new[2*D-1:D]              = pixel_y;
    res_new[4*D-1:2*D]            = pixel_address;
    res_new[4*D+CB-1:4*D]         = pixel_color;
    res_new[4*D+CB]               = flags.busy_res;
    res_new[OUT_W]                = flags.line_done;
    res_new[OUT_W+1]              = flags.write_enable;
  end

  // Advance the result register from the skid entry or the new item; else park in skid
  always_comb begin
    out_res_nxt    = out_res_r;
    out_valid_nxt  = out_valid_r;
    skid_res_nxt   = skid_res_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_pop) begin
      if (skid_valid_r) begin
        out_res_nxt    = skid_res_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_res_nxt   = res_new;
        out_valid_nxt = in_accept;
      end
    end else if (in_accept) begin
      skid_res_nxt   = res_new;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r[OUT_W-1:0];
  assign out_tlast  = out_res_r[OUT_W];
  assign out_tuser  = out_res_r[OUT_W+1];

`ifndef SYNTHESIS
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while result register is empty");

  a_accept_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted item left no result");

  a_skid_only_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid entry filled without a stalled result");
`endif

endmodule

/* sv/lrast_core.sv */
// Line state, Bresenham step logic, clipping and address of one result item.
module lrast_core #(
  parameter int COORD_BITS = 16,
  parameter int DIM_BITS   = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_accept,
  input  logic                              mode,
  input  logic signed [COORD_BITS-1:0]      x_start,
  input  logic signed [COORD_BITS-1:0]      y_start,
  input  logic signed [COORD_BITS-1:0]      x_end,
  input  logic signed [COORD_BITS-1:0]      y_end,
  input  logic [lrast_pkg::COLOR_BITS-1:0]  line_color,
  input  logic [DIM_BITS-1:0]               screen_width,
  input  logic [DIM_BITS-1:0]               screen_height,
  output lrast_pkg::lrast_flags_t           flags,
  output logic [DIM_BITS-1:0]               pixel_x,
  output logic [DIM_BITS-1:0]               pixel_y,
  output logic [2*DIM_BITS-1:0]             pixel_address,
  output logic [lrast_pkg::COLOR_BITS-1:0]  pixel_color
);

  localparam int C = COORD_BITS;
  localparam int D = DIM_BITS;
  localparam int W = COORD_BITS + DIM_BITS;

  // Line state
  logic signed [C-1:0]             cur_x_r, cur_y_r, end_x_r, end_y_r;
  logic signed [C-1:0]             cur_x_nxt, cur_y_nxt, end_x_nxt, end_y_nxt;
  logic signed [C+1:0]             err_r, err_nxt;
  logic [C:0]                      dx_r, dy_r, dx_nxt, dy_nxt;
  logic                            neg_x_r, neg_y_r, x_major_r, active_r;
  logic                            neg_x_nxt, neg_y_nxt, x_major_nxt, active_nxt;
  logic [lrast_pkg::COLOR_BITS-1:0] color_r, color_nxt;

  // Load setup
  logic signed [C:0]   ld_dx, ld_dy;
  logic [C:0]          ld_adx, ld_ady, ld_major;
  logic                ld_x_major;

  // Step datapath
  logic                is_load, is_step, moving;
  logic [C:0]          st_minor, st_major;
  logic signed [C+1:0] err_sub;
  logic signed [C-1:0] px, py;
  logic [W-1:0]        px_ext, py_ext;
  logic                on_screen;
  logic [2*D-1:0]      addr_mul;

  assign is_load = in_accept && (mode == lrast_pkg::MODE_LOAD);
  assign is_step = in_accept && (mode == lrast_pkg::MODE_STEP) && active_r;

  // Deltas, directions and major axis of a new line
  always_comb begin
    ld_dx      = {x_end[C-1], x_end} - {x_start[C-1], x_start};
    ld_dy      = {y_end[C-1], y_end} - {y_start[C-1], y_start};
    ld_adx     = ld_dx[C] ? (C+1)'(-ld_dx) : ld_dx;
    ld_ady     = ld_dy[C] ? (C+1)'(-ld_dy) : ld_dy;
    ld_x_major = ld_adx > ld_ady;
    ld_major   = ld_x_major ? ld_adx : ld_ady;
  end

  // Error update of one step
  assign moving   = x_major_r ? (cur_x_r != end_x_r) : (cur_y_r != end_y_r);
  assign st_minor = x_major_r ? dy_r : dx_r;
  assign st_major = x_major_r ? dx_r : dy_r;
  assign err_sub  = err_r - $signed({1'b0, st_minor});

  // Next state
  always_comb begin
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    end_x_nxt   = end_x_r;
    end_y_nxt   = end_y_r;
    err_nxt     = err_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    neg_x_nxt   = neg_x_r;
    neg_y_nxt   = neg_y_r;
    x_major_nxt = x_major_r;
    color_nxt   = color_r;
    active_nxt  = active_r;
    if (is_load) begin
      cur_x_nxt   = x_start;
      cur_y_nxt   = y_start;
      end_x_nxt   = x_end;
      end_y_nxt   = y_end;
      dx_nxt      = ld_adx;
      dy_nxt      = ld_ady;
      neg_x_nxt   = ld_dx[C];
      neg_y_nxt   = ld_dy[C];
      x_major_nxt = ld_x_major;
      err_nxt     = $signed({1'b0, ld_major >> 1});
      color_nxt   = line_color;
      active_nxt  = 1'b1;
    end else if (is_step) begin
      if (moving) begin
        err_nxt = err_sub;
        if (err_sub < 0) begin
          err_nxt = err_sub + $signed({1'b0, st_major});
          if (x_major_r) begin
            cur_y_nxt = neg_y_r ? cur_y_r - C'(1) : cur_y_r + C'(1);
          end else begin
            cur_x_nxt = neg_x_r ? cur_x_r - C'(1) : cur_x_r + C'(1);
          end
        end
        if (x_major_r) begin
          cur_x_nxt = neg_x_r ? cur_x_r - C'(1) : cur_x_r + C'(1);
        end else begin
          cur_y_nxt = neg_y_r ? cur_y_r - C'(1) : cur_y_r + C'(1);
        end
      end else begin
        active_nxt = 1'b0;
      end
    end
  end

  // Pixel of this step and its clipping
  always_comb begin
    px        = moving ? cur_x_r : end_x_r;
    py        = moving ? cur_y_r : end_y_r;
    px_ext    = {{D{1'b0}}, px};
    py_ext    = {{D{1'b0}}, py};
    on_screen = !px[C-1] && !py[C-1] &&
                (px_ext < {{C{1'b0}}, screen_width}) &&
                (py_ext < {{C{1'b0}}, screen_height});
    addr_mul  = {{D{1'b0}}, screen_width} * {{D{1'b0}}, py_ext[D-1:0]};
  end

  // Result fields; pixel fields are zero unless the pixel is written
  always_comb begin
    flags.write_enable = is_step && on_screen;
    flags.line_done    = is_step && !moving;
    flags.busy_res     = active_nxt;
    pixel_x            = '0;
    pixel_y            = '0;
    pixel_address      = '0;
    pixel_color        = '0;
    if (flags.write_enable) begin
      pixel_x       = px_ext[D-1:0];
      pixel_y       = py_ext[D-1:0];
      pixel_address = addr_mul + {{D{1'b0}}, px_ext[D-1:0]};
      pixel_color   = color_r;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
      err_r     <= '0;
      dx_r      <= '0;
      dy_r      <= '0;
      neg_x_r   <= 1'b0;
      neg_y_r   <= 1'b0;
      x_major_r <= 1'b0;
      color_r   <= '0;
      active_r  <= 1'b0;
    end else begin
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      end_x_r   <= end_x_nxt;
      end_y_r   <= end_y_nxt;
      err_r     <= err_nxt;
      dx_r      <= dx_nxt;
      dy_r      <= dy_nxt;
      neg_x_r   <= neg_x_nxt;
      neg_y_r   <= neg_y_nxt;
      x_major_r <= x_major_nxt;
      color_r   <= color_nxt;
      active_r  <= active_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_ends_line : assert property (@(posedge clk) disable iff (!rst_n)
    flags.line_done |=> !active_r)
    else $error("line still active after its end point");

  a_load_starts_line : assert property (@(posedge clk) disable iff (!rst_n)
    is_load |=> active_r && (cur_x_r == $past(x_start)) && (end_y_r == $past(y_end)))
    else $error("load did not set up the line");

  a_write_needs_line : assert property (@(posedge clk) disable iff (!rst_n)
    flags.write_enable |-> active_r && !flags.line_done || active_r && !moving)
    else $error("pixel written without an active line");
`endif

endmodule
